// File: rtl/hgpr_pkg.sv
`timescale 1ns / 1ps

package hgpr_pkg;

  localparam int MAX_SIZE  = 255;
  localparam int MAX_SCALE = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 32;

  typedef enum logic [1:0] {
    SHAPE_SQUARE  = 2'd0,
    SHAPE_DIAMOND = 2'd1,
    SHAPE_CIRCLE  = 2'd2,
    SHAPE_CROSS   = 2'd3
  } glyph_shape_e;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_STROKE = 2'd1,
    CLS_FILL   = 2'd2
  } pixel_class_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE     = 3'd0,
    REG_ACROSS    = 3'd1,
    REG_DOWN      = 3'd2,
    REG_THICKNESS = 3'd3,
    REG_FILL      = 3'd4,
    REG_STROKE    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    glyph_shape_e shape;
    logic [7:0]   width;
    logic [7:0]   height;
    logic [3:0]   thick;
    logic [31:0]  fill;
    logic [31:0]  stroke;
  } cfg_t;

  typedef struct packed {
    logic         drawn;
    logic         in_range;
    logic         is_circle;
    pixel_class_e cls_pre;
    logic [19:0]  dx2;
    logic [19:0]  dy2;
    logic [15:0]  inner2;
    logic [15:0]  outer2;
  } geom_t;

endpackage

// File: rtl/hgpr_in_if.sv
`timescale 1ns / 1ps

interface hgpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] row;
  logic [7:0] column;

  modport source (output valid, output row, output column, input ready);
  modport sink (input valid, input row, input column, output ready);
endinterface

// File: rtl/hgpr_out_if.sv
`timescale 1ns / 1ps

interface hgpr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_color;
  logic [1:0]  pixel_class;
  logic        drawn;

  modport source (output valid, output pixel_color, output pixel_class, output drawn,
                  input ready);
  modport sink (input valid, input pixel_color, input pixel_class, input drawn,
                output ready);
endinterface

// File: rtl/hgpr_cfg.sv
`timescale 1ns / 1ps

module hgpr_cfg import hgpr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_data_i,
  output cfg_t                 cfg_o
);

  glyph_shape_e shape_q;
  logic [7:0]   across_q;
  logic [7:0]   down_q;
  logic [3:0]   thick_q;
  logic [31:0]  fill_q;
  logic [31:0]  stroke_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= SHAPE_SQUARE;
      across_q <= 8'd7;
      down_q   <= 8'd7;
      thick_q  <= 4'd1;
      fill_q   <= '0;
      stroke_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SHAPE:     shape_q  <= glyph_shape_e'(cfg_data_i[1:0]);
        REG_ACROSS:    across_q <= cfg_data_i[7:0];
        REG_DOWN:      down_q   <= cfg_data_i[7:0];
        REG_THICKNESS: thick_q  <= cfg_data_i[3:0];
        REG_FILL:      fill_q   <= cfg_data_i[31:0];
        REG_STROKE:    stroke_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.shape  = shape_q;
    cfg_o.width  = (32'(across_q) > MAX_SIZE) ? 8'(MAX_SIZE) : across_q;
    cfg_o.height = (32'(down_q) > MAX_SIZE) ? 8'(MAX_SIZE) : down_q;
    cfg_o.thick  = (32'(thick_q) > MAX_SCALE) ? 4'(MAX_SCALE) : thick_q;
    cfg_o.fill   = fill_q;
    cfg_o.stroke = stroke_q;
  end

endmodule

// File: rtl/hgpr_geom.sv
`timescale 1ns / 1ps

module hgpr_geom import hgpr_pkg::*; (
  input  logic [7:0] row_i,
  input  logic [7:0] column_i,
  input  cfg_t       cfg_i,
  output geom_t      geom_o
);

  logic signed [11:0] i_s, j_s, w_s, h_s, s_s;
  logic signed [11:0] diff, anti, adiff, aanti;
  logic signed [11:0] m, tf, ts, da, db, dc, dd;
  logic signed [11:0] dx, dy, inner;
  logic [9:0]         adx, ady;
  logic [7:0]         ainner;
  logic               sq_fill, dm_fill, dm_stroke, cr_stroke;

  assign i_s = $signed({4'b0, row_i});
  assign j_s = $signed({4'b0, column_i});
  assign w_s = $signed({4'b0, cfg_i.width});
  assign h_s = $signed({4'b0, cfg_i.height});
  assign s_s = $signed({8'b0, cfg_i.thick});

  // Cross: row is y, column is x.
  assign diff      = j_s - i_s;
  assign anti      = w_s - 12'sd1 - j_s - i_s;
  assign adiff     = (diff < 0) ? -diff : diff;
  assign aanti     = (anti < 0) ? -anti : anti;
  assign cr_stroke = (adiff < s_s) || (aanti < s_s);

  assign sq_fill = (s_s < i_s + 12'sd1) && (s_s < w_s - i_s) &&
                   (s_s < j_s + 12'sd1) && (s_s < h_s - j_s);

  assign m  = (w_s + 12'sd1) >>> 1;
  assign tf = m - 12'sd1 + s_s;
  assign ts = m - 12'sd2;
  assign da = i_s + j_s;
  assign db = w_s - 12'sd1 - i_s + j_s;
  assign dc = w_s - 12'sd1 - i_s + h_s - 12'sd1 - j_s;
  assign dd = i_s + h_s - 12'sd1 - j_s;
  assign dm_fill   = (da > tf) && (db > tf) && (dc > tf) && (dd > tf);
  assign dm_stroke = (da > ts) && (db > ts) && (dc > ts) && (dd > ts);

  assign dx     = (i_s <<< 1) - w_s + 12'sd1;
  assign dy     = (j_s <<< 1) - h_s + 12'sd1;
  assign inner  = w_s - (s_s <<< 1);
  assign adx    = (dx < 0) ? 10'(-dx) : dx[9:0];
  assign ady    = (dy < 0) ? 10'(-dy) : dy[9:0];
  assign ainner = (inner < 0) ? 8'(-inner) : inner[7:0];

  always_comb begin
    geom_o.drawn     = (cfg_i.width >= 8'd2) && (cfg_i.height >= 8'd2);
    geom_o.is_circle = (cfg_i.shape == SHAPE_CIRCLE);
    geom_o.dx2       = 20'(adx) * 20'(adx);
    geom_o.dy2       = 20'(ady) * 20'(ady);
    geom_o.inner2    = 16'(ainner) * 16'(ainner);
    geom_o.outer2    = 16'(cfg_i.width) * 16'(cfg_i.width);
    if (cfg_i.shape == SHAPE_CROSS) begin
      geom_o.in_range = (row_i < cfg_i.height) && (column_i < cfg_i.width);
    end else begin
      geom_o.in_range = (row_i < cfg_i.width) && (column_i < cfg_i.height);
    end
    case (cfg_i.shape)
      SHAPE_SQUARE:  geom_o.cls_pre = sq_fill ? CLS_FILL : CLS_STROKE;
      SHAPE_DIAMOND: geom_o.cls_pre = dm_fill ? CLS_FILL :
                                      (dm_stroke ? CLS_STROKE : CLS_NONE);
      SHAPE_CROSS:   geom_o.cls_pre = cr_stroke ? CLS_STROKE : CLS_NONE;
      default:       geom_o.cls_pre = CLS_NONE;
    endcase
  end

endmodule

// File: rtl/hgpr_resolve.sv
`timescale 1ns / 1ps

module hgpr_resolve import hgpr_pkg::*; (
  input  geom_t        geom_i,
  input  logic [31:0]  fill_i,
  input  logic [31:0]  stroke_i,
  output pixel_class_e cls_o,
  output logic [31:0]  color_o
);

  logic [20:0]  dist_sq;
  pixel_class_e circ_cls;

  assign dist_sq = {1'b0, geom_i.dx2} + {1'b0, geom_i.dy2};

  always_comb begin
    if (dist_sq < {5'b0, geom_i.inner2}) begin
      circ_cls = CLS_FILL;
    end else if (dist_sq < {5'b0, geom_i.outer2}) begin
      circ_cls = CLS_STROKE;
    end else begin
      circ_cls = CLS_NONE;
    end

    if (!geom_i.drawn || !geom_i.in_range) begin
      cls_o = CLS_NONE;
    end else if (geom_i.is_circle) begin
      cls_o = circ_cls;
    end else begin
      cls_o = geom_i.cls_pre;
    end

    case (cls_o)
      CLS_FILL:   color_o = fill_i;
      CLS_STROKE: color_o = stroke_i;
      default:    color_o = '0;
    endcase
  end

endmodule

// File: rtl/handle_glyph_pixel_rasterizer.sv
`timescale 1ns / 1ps
// Three-register pipeline: a pixel passes the input, products and result registers in order.
// Throughput: one pixel per cycle while the result channel is not stalled by res_o.ready.
// The square terms of the circle test are registered before the distance add and compare.
// Reset (asynchronous, active low) empties the pipeline and sets the config registers to their defaults.

module handle_glyph_pixel_rasterizer import hgpr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_data_i,
  hgpr_in_if.sink              in_i,
  hgpr_out_if.source           res_o
);

  cfg_t         cfg;
  geom_t        geom;
  pixel_class_e cls;
  logic [31:0]  color;

  logic         v0_q, v1_q, v2_q;
  logic         en0, en1, en2;
  logic [7:0]   row_q, col_q;
  geom_t        geom_q;
  pixel_class_e cls_q;
  logic [31:0]  color_q;
  logic         drawn_q;

  hgpr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hgpr_geom u_geom (
    .row_i    (row_q),
    .column_i (col_q),
    .cfg_i    (cfg),
    .geom_o   (geom)
  );

  hgpr_resolve u_resolve (
    .geom_i   (geom_q),
    .fill_i   (cfg.fill),
    .stroke_i (cfg.stroke),
    .cls_o    (cls),
    .color_o  (color)
  );

  assign en2 = !v2_q || res_o.ready;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;

  assign in_i.ready = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en0) begin
        v0_q <= in_i.valid;
      end
      if (en1) begin
        v1_q <= v0_q;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_i.valid) begin
      row_q <= in_i.row;
      col_q <= in_i.column;
    end
    if (en1 && v0_q) begin
      geom_q <= geom;
    end
    if (en2 && v1_q) begin
      cls_q   <= cls;
      color_q <= color;
      drawn_q <= geom_q.drawn;
    end
  end

  assign res_o.valid       = v2_q;
  assign res_o.pixel_color = color_q;
  assign res_o.pixel_class = cls_q;
  assign res_o.drawn       = drawn_q;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v0_q)
    else $error("Accepted pixel did not enter the input register.");

  a_undrawn_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.drawn) |-> (res_o.pixel_class == CLS_NONE &&
                                       res_o.pixel_color == 32'd0))
    else $error("Undrawn glyph produced a visible pixel.");

  a_clear_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.pixel_class == CLS_NONE) |-> (res_o.pixel_color == 32'd0))
    else $error("Transparent pixel carries a colour.");

  a_class_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.pixel_class != 2'd3))
    else $error("Pixel class out of range.");

  a_mid_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && en2) |=> v2_q)
    else $error("Middle stage item was lost on its way to the result register.");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hgpr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [31:0]  color;
    pixel_class_e cls;
    logic         drawn;
  } pixel_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DW-1:0]    cfg_data;

  hgpr_in_if  pix_if ();
  hgpr_out_if res_if ();

  handle_glyph_pixel_rasterizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (pix_if),
    .res_o      (res_if)
  );

  cfg_t          glyph_cfg;
  pixel_result_t pending_pixels[$];
  int            source_idle_pct = 0;
  int            sink_idle_pct = 0;
  int            stall_left = 0;
  int            mismatches = 0;
  int            pixels_sent = 0;
  int            pixels_checked = 0;
  int            settings_used = 0;
  int            not_drawn_seen = 0;
  int            class_seen[3] = '{0, 0, 0};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #400000;
    $display("Timeout with %0d results outstanding.", pending_pixels.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic pixel_result_t predict_pixel(input logic [7:0] r, input logic [7:0] c);
    int            i, j, w, h, s;
    int            m, lo, sum_b, sum_c, sum_d, dx, dy, dist_sq, inner;
    pixel_result_t res;
    i = int'(r);
    j = int'(c);
    w = int'(glyph_cfg.width);
    h = int'(glyph_cfg.height);
    s = (glyph_cfg.thick > MAX_SCALE) ? MAX_SCALE : int'(glyph_cfg.thick);
    res.color = '0;
    res.cls = CLS_NONE;
    res.drawn = 1'b0;
    if (w < 2 || h < 2) begin
      return res;
    end
    res.drawn = 1'b1;
    if (glyph_cfg.shape == SHAPE_CROSS) begin
      if (i < h && j < w) begin
        dx = j - i;
        if (dx < 0) dx = -dx;
        dy = w - 1 - j - i;
        if (dy < 0) dy = -dy;
        if (dx < s || dy < s) res.cls = CLS_STROKE;
      end
    end else if (i < w && j < h) begin
      case (glyph_cfg.shape)
        SHAPE_SQUARE: begin
          if (i + 1 > s && s < w - i && j + 1 > s && s < h - j) res.cls = CLS_FILL;
          else res.cls = CLS_STROKE;
        end
        SHAPE_DIAMOND: begin
          m = (w + 1) / 2;
          lo = i + j;
          sum_b = (w - 1 - i) + j;
          sum_c = (w - 1 - i) + (h - 1 - j);
          sum_d = i + (h - 1 - j);
          if (sum_b < lo) lo = sum_b;
          if (sum_c < lo) lo = sum_c;
          if (sum_d < lo) lo = sum_d;
          if (lo > m - 1 + s) res.cls = CLS_FILL;
          else if (lo > m - 2) res.cls = CLS_STROKE;
        end
        default: begin
          dx = 2 * i - w + 1;
          dy = 2 * j - h + 1;
          dist_sq = dx * dx + dy * dy;
          inner = w - 2 * s;
          if (dist_sq < inner * inner) res.cls = CLS_FILL;
          else if (dist_sq < w * w) res.cls = CLS_STROKE;
        end
      endcase
    end
    if (res.cls == CLS_FILL) res.color = glyph_cfg.fill;
    else if (res.cls == CLS_STROKE) res.color = glyph_cfg.stroke;
    return res;
  endfunction

  function automatic logic [7:0] pick_size();
    case ($urandom_range(19))
      0: return 8'd1;
      1, 2: return 8'd255;
      3: return 8'd2;
      default: return 8'($urandom_range(3, 40));
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] c);
    while ($urandom_range(99) < source_idle_pct) begin
      pix_if.valid = 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid = 1'b1;
    pix_if.row = r;
    pix_if.column = c;
    do @(posedge clk_i); while (!pix_if.ready);
    pending_pixels.push_back(predict_pixel(r, c));
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    pix_if.valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      REG_SHAPE:     glyph_cfg.shape = glyph_shape_e'(data[1:0]);
      REG_ACROSS:    glyph_cfg.width = data[7:0];
      REG_DOWN:      glyph_cfg.height = data[7:0];
      REG_THICKNESS: glyph_cfg.thick = data[3:0];
      REG_FILL:      glyph_cfg.fill = data;
      REG_STROKE:    glyph_cfg.stroke = data;
      default: ;
    endcase
  endtask

  task automatic set_glyph(input glyph_shape_e shape, input logic [7:0] w, input logic [7:0] h,
                           input logic [3:0] s);
    wait_idle();
    write_reg(REG_SHAPE, 32'(shape));
    write_reg(REG_ACROSS, 32'(w));
    write_reg(REG_DOWN, 32'(h));
    write_reg(REG_THICKNESS, 32'(s));
    settings_used++;
  endtask

  task automatic set_colours(input logic [31:0] fill, input logic [31:0] stroke);
    wait_idle();
    write_reg(REG_FILL, fill);
    write_reg(REG_STROKE, stroke);
  endtask

  task automatic test_reset_defaults();
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd3, 8'd3);
    send_pixel(8'd6, 8'd6);
    send_pixel(8'd7, 8'd3);
    send_pixel(8'd254, 8'd254);
  endtask

  task automatic test_each_shape();
    set_colours(32'hFFFF_FFFF, 32'h5AA5_C33C);
    for (int k = 0; k < 4; k++) begin
      set_glyph(glyph_shape_e'(k), 8'd9, 8'd7, 4'd2);
      send_pixel(8'd4, 8'd3);
      send_pixel(8'd0, 8'd0);
      send_pixel(8'd8, 8'd6);
      send_pixel(8'd254, 8'd0);
    end
  endtask

  task automatic test_special_cases();
    set_colours(32'h0000_0000, 32'hFFFF_FFFF);
    set_glyph(SHAPE_SQUARE, 8'd1, 8'd9, 4'd1);
    send_pixel(8'd0, 8'd0);
    set_glyph(SHAPE_DIAMOND, 8'd9, 8'd1, 4'd1);
    send_pixel(8'd0, 8'd0);
    set_glyph(SHAPE_CROSS, 8'd11, 8'd11, 4'd0);
    send_pixel(8'd5, 8'd5);
    set_glyph(SHAPE_CIRCLE, 8'd255, 8'd255, 4'd15);
    send_pixel(8'd127, 8'd127);
    send_pixel(8'd0, 8'd127);
    set_glyph(SHAPE_CIRCLE, 8'd5, 8'd5, 4'd4);
    send_pixel(8'd2, 8'd2);
    // A write to an index past the register list must leave the glyph as it was.
    wait_idle();
    write_reg(REG_UNUSED, 32'h0000_0001);
    send_pixel(8'd2, 8'd2);
    send_pixel(8'd0, 8'd2);
  endtask

  task automatic test_random_pixels(input int n_items);
    int         sent;
    int         burst;
    int         bound;
    logic [7:0] w, h;
    logic [3:0] s;
    sent = 0;
    while (sent < n_items) begin
      w = pick_size();
      h = pick_size();
      s = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
      set_colours($urandom(), $urandom());
      set_glyph(glyph_shape_e'($urandom_range(3)), w, h, s);
      bound = ((w > h) ? int'(w) : int'(h)) + 3;
      if (bound > 254) bound = 254;
      burst = $urandom_range(25, 60);
      repeat (burst) begin
        if ($urandom_range(99) < 85) send_pixel(8'($urandom_range(bound)), 8'($urandom_range(bound)));
        else send_pixel(8'($urandom_range(254)), 8'($urandom_range(254)));
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    set_colours($urandom(), $urandom());
    set_glyph(SHAPE_CIRCLE, 8'd16, 8'd16, 4'd3);
    stall_left = 300;
    repeat (60) send_pixel(8'($urandom_range(17)), 8'($urandom_range(17)));
  endtask

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else begin
        res_if.ready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    pixel_result_t want;
    pixel_result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.color = res_if.pixel_color;
      got.cls = pixel_class_e'(res_if.pixel_class);
      got.drawn = res_if.drawn;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result beat with nothing expected: colour %h class %0d drawn %b",
                   $time, got.color, got.cls, got.drawn);
        end
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        class_seen[want.cls]++;
        if (!want.drawn) not_drawn_seen++;
        if (got.color !== want.color || got.cls !== want.cls || got.drawn !== want.drawn) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: pixel %0d: colour %h/%h class %0d/%0d drawn %b/%b (expected/actual)",
                     $time, pixels_checked, want.color, got.color, want.cls, got.cls,
                     want.drawn, got.drawn);
          end
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_SHAPE;
    cfg_data = '0;
    pix_if.valid = 1'b0;
    pix_if.row = '0;
    pix_if.column = '0;
    glyph_cfg = '{shape: SHAPE_SQUARE, width: 8'd7, height: 8'd7, thick: 4'd1,
                  fill: 32'd0, stroke: 32'd0};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    source_idle_pct = 37;
    sink_idle_pct = 83;
    test_reset_defaults();
    test_each_shape();
    test_special_cases();
    test_random_pixels(400);

    source_idle_pct = 83;
    sink_idle_pct = 37;
    test_random_pixels(400);

    source_idle_pct = 0;
    sink_idle_pct = 0;
    test_backpressure();
    test_random_pixels(400);

    pix_if.valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d of %0d pixels over %0d glyph settings, all four shapes.",
             pixels_checked, pixels_sent, settings_used);
    $display("Classes seen: %0d fill, %0d stroke, %0d transparent, %0d not drawn; %0d mismatches.",
             class_seen[CLS_FILL], class_seen[CLS_STROKE], class_seen[CLS_NONE],
             not_drawn_seen, mismatches);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/hgpr_pkg.sv
rtl/hgpr_in_if.sv
rtl/hgpr_out_if.sv
rtl/hgpr_cfg.sv
rtl/hgpr_geom.sv
rtl/hgpr_resolve.sv
rtl/handle_glyph_pixel_rasterizer.sv
sim/tb_top.sv
